// File: rtl/signed_divider_64_core_defines.svh
// assertion macros for the signed 64-bit divider core
// no dependencies; included by the top level only
`ifndef SIGNED_DIVIDER_64_CORE_DEFINES_SVH
`define SIGNED_DIVIDER_64_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SD64_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SD64_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/sd64_pkg.sv
// shared types, constants and the one-bit division step of the divider core
// no dependencies
package sd64_pkg;

   localparam int DATA_W = 64;
   // one pipeline stage per quotient bit, behind the magnitude stage
   localparam int STEPS  = DATA_W;

   typedef struct packed {
      logic              neg_q;  // exactly one operand negative
      logic              neg_r;  // dividend negative
      logic [DATA_W-1:0] n;      // dividend magnitude, shifted out msb first
      logic [DATA_W-1:0] d;      // divisor magnitude
      logic [DATA_W-1:0] q;      // quotient bits so far
      logic [DATA_W-1:0] r;      // partial remainder
   } stage_type;

   // one restoring step: shift in the next dividend bit, trial subtract
   function automatic stage_type div_step(input stage_type s);
      stage_type         o;
      logic [DATA_W-1:0] r_sh;
      logic [DATA_W:0]   diff;
      o    = s;
      r_sh = {s.r[DATA_W-2:0], s.n[DATA_W-1]};
      diff = {1'b0, r_sh} - {1'b0, s.d};
      o.n  = {s.n[DATA_W-2:0], 1'b0};
      if (!diff[DATA_W]) begin
         o.r = diff[DATA_W-1:0];
         o.q = {s.q[DATA_W-2:0], 1'b1};
      end else begin
         o.r = r_sh;
         o.q = {s.q[DATA_W-2:0], 1'b0};
      end
      return o;
   endfunction

endpackage

// File: rtl/signed_divider_64_core.sv
// signed 64-bit divider core: pipelined restoring division, one bit per stage
// depends on sd64_pkg and signed_divider_64_core_defines.svh
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  req     | in        | req_valid/req_stall  | req_dividend, req_divisor
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_quotient, rsp_remainder
//
// one beat per cycle unless rsp stalls; an accepted beat passes through:
// one magnitude stage, 64 shift-subtract stages (one 64-bit compare/subtract
// each, the deepest logic in the design) and the sign-fix output register.
// reset clears only the valid bits; payload registers are not reset.
// a stalled rsp holds its beat; bubbles collapse, so req keeps being accepted
// until every stage holds a beat, and only then is req_stall raised.
`include "signed_divider_64_core_defines.svh"

module signed_divider_64_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic signed [sd64_pkg::DATA_W-1:0] req_dividend,
   input  logic signed [sd64_pkg::DATA_W-1:0] req_divisor,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [sd64_pkg::DATA_W-1:0] rsp_quotient,
   output logic signed [sd64_pkg::DATA_W-1:0] rsp_remainder
);

   localparam int W = sd64_pkg::DATA_W;
   localparam int S = sd64_pkg::STEPS;

   // stage 0 holds magnitudes, stages 1..S one quotient bit each
   sd64_pkg::stage_type stage_ff [0:S];
   logic [0:S]          valid_ff;
   // ready[k]: stage k may load this cycle; ready[S+1] is the output register
   logic [0:S+1]        ready;

   logic                rsp_valid_ff;
   logic [W-1:0]        quotient_ff;
   logic [W-1:0]        remainder_ff;

   // magnitude stage input
   sd64_pkg::stage_type mag_in;
   logic                num_neg;
   logic                den_neg;

   assign num_neg = req_dividend[W-1];
   assign den_neg = req_divisor[W-1];

   always_comb begin
      mag_in       = '0;
      mag_in.neg_q = num_neg ^ den_neg;
      mag_in.neg_r = num_neg;
      mag_in.n     = num_neg ? (W'(0) - W'(req_dividend)) : W'(req_dividend);
      mag_in.d     = den_neg ? (W'(0) - W'(req_divisor)) : W'(req_divisor);
   end

   // ripple of ready from the output back to the input, so bubbles are filled
   assign ready[S+1] = !rsp_valid_ff || !rsp_stall;
   for (genvar k = 0; k <= S; k++) begin : g_ready
      assign ready[k] = !valid_ff[k] || ready[k+1];
   end

   assign req_stall = !ready[0];

   // magnitude stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (ready[0]) begin
         valid_ff[0] <= req_valid;
      end
      if (ready[0]) begin
         stage_ff[0] <= mag_in;
      end
   end

   // shift-subtract stages, msb of the quotient first
   for (genvar k = 1; k <= S; k++) begin : g_step
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (ready[k]) begin
            valid_ff[k] <= valid_ff[k-1];
         end
         if (ready[k]) begin
            stage_ff[k] <= sd64_pkg::div_step(stage_ff[k-1]);
         end
      end
   end

   // output register with sign correction
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready[S+1]) begin
         rsp_valid_ff <= valid_ff[S];
      end
      if (ready[S+1]) begin
         quotient_ff  <= stage_ff[S].neg_q ? (W'(0) - stage_ff[S].q) : stage_ff[S].q;
         remainder_ff <= stage_ff[S].neg_r ? (W'(0) - stage_ff[S].r) : stage_ff[S].r;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_quotient  = quotient_ff;
   assign rsp_remainder = remainder_ff;

   // an accepted beat always lands in the magnitude stage
   `SD64_ASSERT_NEXT(a_accept_lands, clock, reset, req_valid && !req_stall, valid_ff[0],
      "accepted request beat did not reach the magnitude stage")

   // the input only stalls when the whole pipe and the output are full
   `SD64_ASSERT_IMPLY(a_stall_only_full, clock, reset, req_stall,
      (&valid_ff) && rsp_valid_ff && rsp_stall, "input stalled with a bubble in the pipe")

   // finished remainder magnitude is below a nonzero divisor
   `SD64_ASSERT_IMPLY(a_rem_below_div, clock, reset,
      valid_ff[S] && (stage_ff[S].d != '0), stage_ff[S].r < stage_ff[S].d,
      "remainder magnitude not below divisor")

   // division by zero yields an all-ones unsigned quotient
   `SD64_ASSERT_IMPLY(a_div_zero_ones, clock, reset,
      valid_ff[S] && (stage_ff[S].d == '0), &stage_ff[S].q,
      "divide by zero quotient not all ones")

endmodule

// File: tb/signed_divider_64_core_tb.sv
// self-checking testbench for the signed 64-bit divider core
// depends on sd64_pkg and signed_divider_64_core (and the core's define header)
// directed corner operands, then random batches, mostly under random idling and stalls
module signed_divider_64_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W           = sd64_pkg::DATA_W;
   localparam int LATENCY     = 66;
   localparam int CYCLE_LIMIT = 400000;

   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] ALL_ONES = {W{1'b1}};

   typedef struct {
      logic signed [W-1:0] dividend;
      logic signed [W-1:0] divisor;
   } div_operands_type;

   typedef struct {
      logic signed [W-1:0] quotient;
      logic signed [W-1:0] remainder;
   } quot_rem_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_stall;
   logic signed [W-1:0] req_dividend  = '0;
   logic signed [W-1:0] req_divisor   = '0;
   logic                rsp_valid;
   logic                rsp_stall     = 1'b0;
   logic signed [W-1:0] rsp_quotient;
   logic signed [W-1:0] rsp_remainder;

   div_operands_type pending_operands[$];   // beats not yet accepted, front is on the bus
   quot_rem_type     expected_quot_rem[$];  // predictions for accepted beats, oldest first
   int               mismatches   = 0;
   int               cycle_count  = 0;
   int               stall_left   = 0;
   bit               steady_mode  = 1'b0;   // no idling on either side while set

   signed_divider_64_core i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_dividend  (req_dividend),
      .req_divisor   (req_divisor),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_quotient  (rsp_quotient),
      .rsp_remainder (rsp_remainder)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // restoring division on magnitudes, then sign fix-up
   function automatic quot_rem_type divide_restoring(logic [W-1:0] num, logic [W-1:0] den);
      quot_rem_type res;
      logic [W-1:0] n_mag;
      logic [W-1:0] d_mag;
      logic [W-1:0] quo;
      logic [W-1:0] rem;
      n_mag = num[W-1] ? ('0 - num) : num;
      d_mag = den[W-1] ? ('0 - den) : den;
      quo   = '0;
      rem   = '0;
      for (int i = W - 1; i >= 0; i--) begin
         rem = {rem[W-2:0], n_mag[i]};
         // divisor zero: every trial succeeds, quotient fills with ones
         if (rem >= d_mag) begin
            rem    = rem - d_mag;
            quo[i] = 1'b1;
         end
      end
      // quotient negated when signs differ; most negative / -1 already wrapped in n_mag
      if (num[W-1] != den[W-1])
         quo = '0 - quo;
      // remainder follows the dividend sign
      if (num[W-1])
         rem = '0 - rem;
      res.quotient  = quo;
      res.remainder = rem;
      return res;
   endfunction

   // operand mix: full random, narrow magnitudes, tiny values, extremes
   function automatic logic [W-1:0] random_operand();
      logic [W-1:0] v;
      case ($urandom_range(9))
         0, 1, 2, 3: v = {$urandom, $urandom};
         4, 5:       v = {$urandom, $urandom} >> $urandom_range(W - 1);
         6:          v = W'($urandom_range(15));
         7: begin
            case ($urandom_range(4))
               0:       v = MOST_NEG;
               1:       v = MOST_POS;
               2:       v = '0;
               3:       v = W'(1);
               default: v = ALL_ONES;
            endcase
         end
         default: v = {$urandom, $urandom} >> $urandom_range(W - 1, W / 2);
      endcase
      if ($urandom_range(1) == 1)
         v = '0 - v;
      return v;
   endfunction

   task automatic push_operands(logic [W-1:0] num, logic [W-1:0] den);
      div_operands_type op;
      op.dividend = num;
      op.divisor  = den;
      pending_operands.push_back(op);
   endtask

   task automatic push_random(int count);
      repeat (count) push_operands(random_operand(), random_operand());
   endtask

   task automatic wait_drained();
      while (pending_operands.size() != 0 || expected_quot_rem.size() != 0)
         @(negedge clock);
   endtask

   // request driver: presents the front of the queue, holds it while stalled
   always @(posedge clock) begin : drive_req
      div_operands_type op;
      bit               idle;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            // beat accepted at this edge: predict its result now
            op = pending_operands.pop_front();
            expected_quot_rem.push_back(divide_restoring(op.dividend, op.divisor));
         end
         if (!(req_valid && req_stall)) begin
            idle = !steady_mode && ($urandom_range(99) < 26);
            if (pending_operands.size() != 0 && !idle) begin
               req_valid    <= 1'b1;
               req_dividend <= pending_operands[0].dividend;
               req_divisor  <= pending_operands[0].divisor;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and stall generator
   always @(posedge clock) begin : watch_rsp
      quot_rem_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_quot_rem.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected rsp beat, expected none, actual quotient %h remainder %h",
                        $time, rsp_quotient, rsp_remainder);
            end else begin
               want = expected_quot_rem.pop_front();
               if (rsp_quotient !== want.quotient) begin
                  mismatches++;
                  $display("%0t: quotient expected %h actual %h",
                           $time, want.quotient, rsp_quotient);
               end
               if (rsp_remainder !== want.remainder) begin
                  mismatches++;
                  $display("%0t: remainder expected %h actual %h",
                           $time, want.remainder, rsp_remainder);
               end
            end
         end
         // random stalls, with rare long bursts that fill the pipe and
         // push back on req
         if (steady_mode) begin
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if ($urandom_range(299) == 0) begin
            stall_left = $urandom_range(150, 70);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < 26);
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // stimulus and end of test
   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed corners
      push_operands(64'sd7, 64'sd2);
      push_operands(-64'sd7, 64'sd2);
      push_operands(64'sd7, -64'sd2);
      push_operands(-64'sd7, -64'sd2);
      push_operands('0, 64'sd1);
      push_operands('0, '0);            // zero by zero
      push_operands(64'sd12345, '0);    // positive by zero
      push_operands(-64'sd12345, '0);   // negative by zero
      push_operands(MOST_POS, '0);
      push_operands(MOST_NEG, '0);
      push_operands(MOST_NEG, ALL_ONES); // overflow wrap
      push_operands(MOST_NEG, 64'sd1);
      push_operands(MOST_NEG, MOST_NEG);
      push_operands(MOST_NEG, MOST_POS);
      push_operands(MOST_POS, MOST_NEG);
      push_operands(MOST_POS, MOST_POS);
      push_operands(MOST_POS, ALL_ONES);
      push_operands(64'sd1, MOST_NEG);
      push_operands(ALL_ONES, ALL_ONES);
      push_operands(64'sd3, 64'sd1000);  // divisor larger than dividend
      push_operands(ALL_ONES, 64'sd2);
      push_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
      push_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h0000_0000_0000_0003);

      // sender holds off until the pipe is empty
      wait_drained();
      push_random(300);
      wait_drained();

      // back-to-back stretch, no idling anywhere
      steady_mode = 1'b1;
      push_random(150);
      wait_drained();
      steady_mode = 1'b0;

      push_random(250);
      wait_drained();

      // let any stray beat show up
      repeat (LATENCY + 4) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+rtl
rtl/sd64_pkg.sv
rtl/signed_divider_64_core.sv
tb/signed_divider_64_core_tb.sv
